// ===== src/shared_buffer_multi_queue_defines.svh =====
// Assertion macros shared by the shared-buffer queue RTL.
`ifndef SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH
`define SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SHQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/shq_pkg.sv =====
// Shared constants, codes and interface types of the shared-buffer queue block.
package shq_pkg;

  // Sizing of the slot store and the queue set.
  localparam int NUM_SLOTS  = 16;
  localparam int NUM_QUEUES = 4;

  // Fixed field widths of the item and result.
  localparam int DATA_W   = 32;
  localparam int QID_W    = 2;
  localparam int STATUS_W = 2;

  // A pointer holds a slot number or the null value NUM_SLOTS.
  localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(NUM_SLOTS);

  // Operation codes.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Operation as seen when the item is accepted (drives the memory reads).
  typedef struct packed {
    logic             op;
    logic [QID_W-1:0] qid;
  } shq_issue_t;

  // Operation as seen when the item completes (drives all updates).
  typedef struct packed {
    logic             fire;
    logic             op;
    logic [QID_W-1:0] qid;
  } shq_finish_t;

  // Write request to the link memory.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [PTR_W-1:0]  data;
  } shq_link_wr_t;

  // Write request to the data memory; the data comes from the held item.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } shq_slot_wr_t;

endpackage

// ===== src/shared_buffer_multi_queue.sv =====
// Several FIFO queues sharing one slot store: each item is an enqueue or a
// dequeue on one queue and gives one result with data and status. When an
// item is accepted the link and data memories are read at the slot the
// operation needs; when it completes the pointers are updated, one link and
// one data entry are written back and the result is loaded into the output
// register. A new item is taken only after the last one has completed; a
// stalled result holds the item in progress until the output register can
// take it. No clearing pass is needed after reset.
module shared_buffer_multi_queue import shq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [QID_W-1:0]           queue_id,
  input  logic signed [DATA_W-1:0]   data_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DATA_W-1:0]   data_out,
  output logic [STATUS_W-1:0]        status
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic                accept;
  logic                finish;
  logic                op_r;
  logic [QID_W-1:0]    qid_r;
  logic [DATA_W-1:0]   data_r;
  logic [PTR_W-1:0]    link_rd;
  logic [DATA_W-1:0]   data_rd;
  logic [SLOT_W-1:0]   link_rd_addr;
  logic [SLOT_W-1:0]   data_rd_addr;
  logic [STATUS_W-1:0] fin_status;
  shq_issue_t          issue;
  shq_finish_t         fin;
  shq_link_wr_t        link_wr;
  shq_slot_wr_t        slot_wr;

  // Handshake and sequencing.
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state == S_BUSY) && (!out_valid || out_ready);

  always_comb begin
    case (state)
      S_IDLE:  state_next = accept ? S_BUSY : S_IDLE;
      S_BUSY:  state_next = finish ? S_IDLE : S_BUSY;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the accepted item for the update cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op;
      qid_r  <= queue_id;
      data_r <= data_in;
    end
  end

  assign issue.op  = op;
  assign issue.qid = queue_id;
  assign fin.fire  = finish;
  assign fin.op    = op_r;
  assign fin.qid   = qid_r;

  shq_ptr_unit u_ptr (
    .clk          (clk),
    .rst          (rst),
    .issue        (issue),
    .fin          (fin),
    .link_rd      (link_rd),
    .link_rd_addr (link_rd_addr),
    .data_rd_addr (data_rd_addr),
    .link_wr      (link_wr),
    .slot_wr      (slot_wr),
    .status       (fin_status)
  );

  // Next-slot links of queues and the recycled list.
  shq_ram #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (PTR_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr.en),
    .wr_addr (link_wr.addr),
    .wr_data (link_wr.data),
    .rd_en   (accept),
    .rd_addr (link_rd_addr),
    .rd_data (link_rd)
  );

  // Slot payloads.
  shq_ram #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (DATA_W)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (slot_wr.en),
    .wr_addr (slot_wr.addr),
    .wr_data (data_r),
    .rd_en   (accept),
    .rd_addr (data_rd_addr),
    .rd_data (data_rd)
  );

  // Output register: valid flag under reset, payload loaded on completion.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status   <= fin_status;
      data_out <= ((op_r == OP_DEQ) && (fin_status == ST_OK)) ? data_rd : '0;
    end
  end

endmodule

// ===== src/shq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module shq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/shq_ptr_unit.sv =====
// Queue head/tail pointers, free list and slot allocation for the shared buffer.
`include "shared_buffer_multi_queue_defines.svh"
module shq_ptr_unit import shq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  shq_issue_t          issue,
  input  shq_finish_t         fin,
  input  logic [PTR_W-1:0]    link_rd,
  output logic [SLOT_W-1:0]   link_rd_addr,
  output logic [SLOT_W-1:0]   data_rd_addr,
  output shq_link_wr_t        link_wr,
  output shq_slot_wr_t        slot_wr,
  output logic [STATUS_W-1:0] status
);

  // Per-queue pointers. Recycled slots form a list threaded through the link
  // memory; slots never used yet are handed out in order by a fill count.
  logic [PTR_W-1:0] head [NUM_QUEUES];
  logic [PTR_W-1:0] tail [NUM_QUEUES];
  logic [PTR_W-1:0] free_head;
  logic [PTR_W-1:0] fresh;

  logic [QIDX_W-1:0] iq;
  logic [QIDX_W-1:0] fq;
  logic [PTR_W-1:0]  head_iss;
  logic [PTR_W-1:0]  head_q;
  logic [PTR_W-1:0]  tail_q;
  logic [PTR_W-1:0]  enq_slot;
  logic              q_ok;
  logic              recycled;
  logic              fresh_left;
  logic              enq_ok;
  logic              deq_ok;
  logic              is_enq;

  // Read addresses at accept: the free-list head for an enqueue, the queue
  // head for a dequeue.
  always_comb begin
    iq           = QIDX_W'(issue.qid);
    head_iss     = head[iq];
    link_rd_addr = (issue.op == OP_ENQ) ? SLOT_W'(free_head) : SLOT_W'(head_iss);
    data_rd_addr = SLOT_W'(head_iss);
  end

  // Decisions at completion.
  always_comb begin
    fq         = QIDX_W'(fin.qid);
    q_ok       = 32'(fin.qid) < 32'(NUM_QUEUES);
    head_q     = head[fq];
    tail_q     = tail[fq];
    recycled   = free_head != NIL_PTR;
    fresh_left = fresh != NIL_PTR;
    is_enq     = fin.op == OP_ENQ;
    enq_ok     = q_ok && (recycled || fresh_left);
    deq_ok     = q_ok && (head_q != NIL_PTR);
    enq_slot   = recycled ? free_head : fresh;

    if (is_enq) begin
      status = enq_ok ? ST_OK : ST_FULL;
    end else begin
      status = deq_ok ? ST_OK : ST_EMPTY;
    end

    // An enqueue links the new slot after a non-empty queue's tail; a
    // dequeue pushes the old head onto the recycled list.
    link_wr.en   = fin.fire && ((is_enq && enq_ok && (head_q != NIL_PTR)) ||
                                (!is_enq && deq_ok));
    link_wr.addr = is_enq ? SLOT_W'(tail_q) : SLOT_W'(head_q);
    link_wr.data = is_enq ? enq_slot : free_head;

    slot_wr.en   = fin.fire && is_enq && enq_ok;
    slot_wr.addr = SLOT_W'(enq_slot);
  end

  // Pointer update. The tail slot's link is never used: a dequeue of the
  // tail slot empties the queue directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= NIL_PTR;
        tail[i] <= NIL_PTR;
      end
      free_head <= NIL_PTR;
      fresh     <= '0;
    end else if (fin.fire) begin
      if (is_enq && enq_ok) begin
        if (recycled) begin
          free_head <= link_rd;
        end else begin
          fresh <= fresh + PTR_W'(1);
        end
        if (head_q == NIL_PTR) begin
          head[fq] <= enq_slot;
        end
        tail[fq] <= enq_slot;
      end else if (!is_enq && deq_ok) begin
        head[fq]  <= (head_q == tail_q) ? NIL_PTR : link_rd;
        free_head <= head_q;
      end
    end
  end

  // The fill count never passes the store size.
  `SHQ_ASSERT_NOW(a_fresh_bound, 1'b1, fresh <= NIL_PTR, "fill count beyond store size")

  // A successful dequeue puts the old head slot at the front of the free list.
  `SHQ_ASSERT_NEXT(a_deq_recycle, fin.fire && !is_enq && deq_ok, free_head == $past(head_q), "dequeued slot not recycled")

  // A successful enqueue makes the new slot the queue's tail.
  `SHQ_ASSERT_NEXT(a_enq_tail, fin.fire && is_enq && enq_ok, tail[$past(fq)] == $past(enq_slot), "enqueued slot not at tail")

endmodule

// ===== tb/sv/shared_buffer_multi_queue_tb.sv =====
// Self-checking testbench for the shared-buffer multi-queue block.
module shared_buffer_multi_queue_tb;
  import shq_pkg::*;

  // Long output hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
  } queue_result_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     op;
  logic [QID_W-1:0]         queue_id;
  logic signed [DATA_W-1:0] data_in;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] data_out;
  logic [STATUS_W-1:0]      status;

  // Shadow copy of the queue store, kept in step with accepted items.
  logic [PTR_W-1:0]  shadow_head [NUM_QUEUES];
  logic [PTR_W-1:0]  shadow_tail [NUM_QUEUES];
  logic [PTR_W-1:0]  shadow_link [NUM_SLOTS];
  logic [DATA_W-1:0] shadow_data [NUM_SLOTS];
  logic [PTR_W-1:0]  shadow_free;
  int                queue_depth [NUM_QUEUES];

  queue_result_t pending_results[$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  enq_stored = 0;
  int  enq_refused = 0;
  int  deq_returned = 0;
  int  deq_refused = 0;
  bit  hold_req = 1'b0;
  bit  sender_no_idle = 1'b0;
  bit  ready_no_idle = 1'b0;

  shared_buffer_multi_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .queue_id  (queue_id),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out),
    .status    (status)
  );

  always #5 clk = ~clk;

  // Gap length: mostly none or short, now and then long.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Applies one operation to the shadow store and returns its result.
  function automatic queue_result_t queue_store_step(input logic o,
                                                     input logic [QID_W-1:0] q,
                                                     input logic [DATA_W-1:0] d);
    queue_result_t    r;
    logic [PTR_W-1:0] slot;
    r.data   = '0;
    r.status = ST_OK;
    if (o == OP_ENQ) begin
      if (int'(q) >= NUM_QUEUES || shadow_free >= NUM_SLOTS) begin
        r.status = ST_FULL;
      end else begin
        slot = shadow_free;
        shadow_free = shadow_link[slot];
        // An empty queue takes the slot as its head; a stale tail is ignored.
        if (shadow_head[q] >= NUM_SLOTS) begin
          shadow_head[q] = slot;
        end else if (shadow_tail[q] < NUM_SLOTS) begin
          shadow_link[shadow_tail[q]] = slot;
        end
        shadow_link[slot] = NIL_PTR;
        shadow_tail[q]    = slot;
        shadow_data[slot] = d;
        queue_depth[q]++;
      end
    end else begin
      if (int'(q) >= NUM_QUEUES || shadow_head[q] >= NUM_SLOTS) begin
        r.status = ST_EMPTY;
      end else begin
        // Unlink the head slot and push it onto the front of the free list.
        slot = shadow_head[q];
        shadow_head[q]    = shadow_link[slot];
        shadow_link[slot] = shadow_free;
        shadow_free       = slot;
        r.data            = shadow_data[slot];
        queue_depth[q]--;
      end
    end
    return r;
  endfunction

  // Picks a queue that holds items, or any queue when all are empty.
  function automatic logic [QID_W-1:0] pick_busy_queue();
    int start;
    int idx;
    start = $urandom_range(0, NUM_QUEUES - 1);
    for (int k = 0; k < NUM_QUEUES; k++) begin
      idx = (start + k) % NUM_QUEUES;
      if (queue_depth[idx] > 0) return QID_W'(idx);
    end
    return QID_W'(start);
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] exp_val,
                                 input logic [DATA_W-1:0] act_val);
    if (mismatches < MAX_REPORTS) begin
      $display("mismatch on %s: expected %h, got %h at %0t", what, exp_val, act_val, $time);
    end
    mismatches++;
  endtask

  // Offers one item, waits for it to be taken, then records its result.
  task automatic send_item(input logic o, input logic [QID_W-1:0] q,
                           input logic [DATA_W-1:0] d);
    queue_result_t r;
    int            gap;
    in_valid <= 1'b1;
    op       <= o;
    queue_id <= q;
    data_in  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = queue_store_step(o, q, d);
    pending_results.push_back(r);
    items_sent++;
    if (o == OP_ENQ) begin
      if (r.status == ST_OK) enq_stored++;
      else enq_refused++;
    end else begin
      if (r.status == ST_OK) deq_returned++;
      else deq_refused++;
    end
    gap = sender_no_idle ? 0 : rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Dequeues from empty queues right after reset, with extreme ignored data.
  task automatic test_empty_queue();
    send_item(OP_DEQ, 2'd0, 32'hFFFF_FFFF);
    send_item(OP_DEQ, 2'd3, 32'h0000_0000);
  endtask

  // Empties a queue, then refills it while its tail still points at the old slot.
  task automatic test_emptied_queue();
    send_item(OP_ENQ, 2'd1, 32'h7FFF_FFFF);
    send_item(OP_DEQ, 2'd1, 32'h1234_5678);
    send_item(OP_DEQ, 2'd1, 32'h0000_0000);
    send_item(OP_ENQ, 2'd1, 32'h8000_0000);
    send_item(OP_DEQ, 2'd1, 32'h0000_0000);
  endtask

  // Fills every slot, then tries to enqueue into the full store.
  task automatic test_store_full();
    logic [DATA_W-1:0] pattern;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      case (i % 6)
        0: pattern = 32'h8000_0000;
        1: pattern = 32'h7FFF_FFFF;
        2: pattern = 32'h0000_0000;
        3: pattern = 32'hFFFF_FFFF;
        4: pattern = 32'hAAAA_AAAA;
        default: pattern = 32'h5555_5555;
      endcase
      send_item(OP_ENQ, QID_W'(i % NUM_QUEUES), pattern);
    end
    send_item(OP_ENQ, 2'd2, 32'hDEAD_BEEF);
    send_item(OP_ENQ, 2'd0, 32'h0BAD_F00D);
  endtask

  // Mixed traffic whose enqueue share shifts so the store swings between full and empty.
  task automatic test_random_traffic(input int n_items);
    int                enq_pct;
    logic              o;
    logic [QID_W-1:0]  q;
    logic [DATA_W-1:0] d;
    enq_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 15;
          1: enq_pct = 50;
          2: enq_pct = 85;
          default: enq_pct = 100;
        endcase
      end
      o = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
      if (o == OP_DEQ && $urandom_range(0, 9) != 0) begin
        q = pick_busy_queue();
      end else begin
        q = QID_W'($urandom_range(0, NUM_QUEUES - 1));
      end
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0: d = 32'h8000_0000;
          1: d = 32'h7FFF_FFFF;
          2: d = 32'h0000_0000;
          default: d = 32'hFFFF_FFFF;
        endcase
      end else begin
        d = $urandom;
      end
      send_item(o, q, d);
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_req = 1'b1;
    sender_no_idle = 1'b1;
    test_random_traffic(40);
    sender_no_idle = 1'b0;
  endtask

  // Both sides run without gaps.
  task automatic test_burst();
    sender_no_idle = 1'b1;
    ready_no_idle = 1'b1;
    test_random_traffic(100);
    sender_no_idle = 1'b0;
    ready_no_idle = 1'b0;
  endtask

  // Result side: random ready gaps plus one long hold-off on request.
  initial begin : receiver
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      gap = ready_no_idle ? 0 : rand_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Compare every accepted result with the oldest expected one.
  always @(posedge clk) begin
    queue_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, data", '0, data_out);
      end else begin
        exp_r = pending_results.pop_front();
        if (data_out !== exp_r.data) report_mismatch("data_out", exp_r.data, data_out);
        if (status !== exp_r.status) begin
          report_mismatch("status", DATA_W'(exp_r.status), DATA_W'(status));
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int waited;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    op       <= OP_ENQ;
    queue_id <= '0;
    data_in  <= '0;
    // The shadow store starts as the block does after reset.
    for (int i = 0; i < NUM_QUEUES; i++) begin
      shadow_head[i] = NIL_PTR;
      shadow_tail[i] = NIL_PTR;
      queue_depth[i] = 0;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      shadow_link[i] = (i + 1 < NUM_SLOTS) ? PTR_W'(i + 1) : NIL_PTR;
      shadow_data[i] = '0;
    end
    shadow_free = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_emptied_queue();
    test_store_full();
    test_backpressure();
    test_random_traffic(370);
    test_burst();
    test_random_traffic(370);
    if (in_valid) in_valid <= 1'b0;

    // Drain what is still in flight, then let the block idle before the final check.
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Sent %0d items: %0d enqueues stored, %0d refused on a full store,",
             items_sent, enq_stored, enq_refused);
    $display("%0d dequeues returned data, %0d found the queue empty; %0d mismatches.",
             deq_returned, deq_refused, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
